@@ rtl/srt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types and codes for the shortest-remaining-time scheduler.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int TIME_W  = 24;
  localparam int FIELD_W = 16;
  localparam int Q_W     = 8;

  // input kind codes (tuser)
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_STEP  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    ST_LOADED  = 3'd0,
    ST_FULL    = 3'd1,
    ST_RAN     = 3'd2,
    ST_IDLE    = 3'd3,
    ST_DONE    = 3'd4,
    ST_CLEARED = 3'd5
  } status_t;

  // one table row as kept in the RAM
  typedef struct packed {
    logic [FIELD_W-1:0] arrival;
    logic [FIELD_W-1:0] remaining;
    logic [FIELD_W-1:0] burst;
  } entry_t;

  typedef struct packed {
    status_t           status;
    logic [3:0]        job_index;
    logic [TIME_W-1:0] slice_start;
    logic [Q_W-1:0]    slice_length;
    logic              finished;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting_time;
  } result_t;

endpackage

@@ rtl/srt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/shortest_remaining_time_scheduler.sv @@
`timescale 1ns / 1ps
// Sequence: a load, a full-table load or a clear goes from IDLE straight to OUT;
//   a step runs SCAN, LAST and DECIDE, then RUN for a slice, plus TA and WT for
//   a slice that finishes its job, before OUT (idle tick / all done skip RUN).
// Throughput: one item at a time; the table scan, one RAM read per entry, sets
//   the step time. s_tready is high only while the sequencer is idle.
// Reset: rst (sync, high) empties the table, zeroes the clock, sets quantum=1.
// ----------------------------------------------------------------------------
// shortest_remaining_time_scheduler
// Preemptive SRT scheduler with time quantum: job table in RAM, serial
// min-search over the table, then a short run/report sequence.
// ----------------------------------------------------------------------------
module shortest_remaining_time_scheduler
  import srt_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic         clk,
  input  logic         rst,
  // config: quantum register
  input  logic         cfg_we,
  input  logic [7:0]   cfg_wdata,
  // input beats
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // [15:0] arrival_time, [31:16] burst_time
  input  logic [1:0]   s_tuser,   // [1:0] kind
  // result beats
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,   // [3:0] job_index, [27:4] slice_start,
                                  // [35:28] slice_length, [36] finished,
                                  // [60:37] finish_time, [84:61] turnaround,
                                  // [108:85] waiting_time, [111:109] zero
  output logic [2:0]   m_tuser    // [2:0] status
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // Sequencer: SCAN issues one RAM read per entry, each compare follows in the
  // next cycle (LAST covers the final compare). DECIDE picks the slice length, RUN
  // spends it, TA/WT finish the completion stats, OUT hands off the result.
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SCAN   = 8'b0000_0010,
    S_LAST   = 8'b0000_0100,
    S_DECIDE = 8'b0000_1000,
    S_RUN    = 8'b0001_0000,
    S_TA     = 8'b0010_0000,
    S_WT     = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t            state;
  logic [Q_W-1:0]    quantum;
  logic [ENTRIES-1:0] entry_valid;
  logic [CNT_W-1:0]  entry_count;
  logic [TIME_W-1:0] current_time;

  logic [IDX_W-1:0]  scan_idx;
  logic              cmp_en;
  logic [IDX_W-1:0]  cmp_idx;
  logic              any_pending;
  logic              found;
  logic [IDX_W-1:0]  best_idx;
  entry_t            best;
  logic [Q_W-1:0]    len;
  result_t           res;
  result_t           out_q;

  logic              s_fire;
  logic              out_free;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  entry_t            ram_rdata;
  logic              table_full;
  logic [Q_W-1:0]    q_eff;
  logic [Q_W-1:0]    add_len;
  logic [TIME_W:0]   time_sum;
  logic [TIME_W-1:0] time_sat;
  logic [FIELD_W-1:0] rem_next;
  logic              better;
  logic [IDX_W+3:0]  best_idx_ext;
  logic [IDX_W+3:0]  cnt_idx_ext;

  assign s_tready   = (state == S_IDLE);
  assign s_fire     = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign table_full = (entry_count >= CNT_W'(ENTRIES));
  assign q_eff      = (quantum == '0) ? Q_W'(1) : quantum;

  // shared saturating clock adder: idle tick adds 1, a slice adds len
  assign add_len  = (state == S_DECIDE) ? Q_W'(1) : len;
  assign time_sum = {1'b0, current_time} + {{(TIME_W + 1 - Q_W){1'b0}}, add_len};
  assign time_sat = time_sum[TIME_W] ? {TIME_W{1'b1}} : time_sum[TIME_W-1:0];
  assign rem_next = best.remaining - {{(FIELD_W - Q_W){1'b0}}, len};

  // only the low 4 bits of a slot number are reported
  assign best_idx_ext = {4'b0, best_idx};
  assign cnt_idx_ext  = {4'b0, entry_count[IDX_W-1:0]};

  // scan compare: least remaining, then earliest arrival, then lowest index
  always_comb begin
    better = !found ||
             (ram_rdata.remaining < best.remaining) ||
             ((ram_rdata.remaining == best.remaining) &&
              (ram_rdata.arrival < best.arrival));
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = best_idx;
    ram_wdata = '{arrival: best.arrival, remaining: rem_next, burst: best.burst};
    if (s_fire && (s_tuser == KIND_LOAD) && !table_full) begin
      ram_we    = 1'b1;
      ram_waddr = entry_count[IDX_W-1:0];
      ram_wdata = '{arrival: s_tdata[15:0], remaining: s_tdata[31:16],
                    burst: s_tdata[31:16]};
    end else if (state == S_RUN) begin
      ram_we = 1'b1;
    end
  end

  srt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= Q_W'(1);
    end else if (cfg_we) begin
      quantum <= cfg_wdata;
    end
  end

  // control and table bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      entry_valid  <= '0;
      entry_count  <= '0;
      current_time <= '0;
      scan_idx     <= '0;
      cmp_en       <= 1'b0;
    end else begin
      cmp_en <= (state == S_SCAN);
      unique case (state)
        S_IDLE: begin
          if (s_fire) begin
            priority case (s_tuser)
              KIND_LOAD: begin
                if (!table_full) begin
                  entry_valid[entry_count[IDX_W-1:0]] <= 1'b1;
                  entry_count <= entry_count + CNT_W'(1);
                end
                state <= S_OUT;
              end
              KIND_STEP: begin
                scan_idx <= '0;
                state    <= S_SCAN;
              end
              KIND_CLEAR: begin
                entry_valid  <= '0;
                entry_count  <= '0;
                current_time <= '0;
                state        <= S_OUT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          if (scan_idx == IDX_W'(ENTRIES - 1)) begin
            state <= S_LAST;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        S_LAST: state <= S_DECIDE;
        S_DECIDE: begin
          if (any_pending && found) begin
            state <= S_RUN;
          end else begin
            if (any_pending) begin
              current_time <= time_sat;
            end
            state <= S_OUT;
          end
        end
        S_RUN: begin
          current_time <= time_sat;
          if (rem_next == '0) begin
            entry_valid[best_idx] <= 1'b0;
            state <= S_TA;
          end else begin
            state <= S_OUT;
          end
        end
        S_TA: state <= S_WT;
        S_WT: state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // search registers and result assembly
  always_ff @(posedge clk) begin
    if (s_fire) begin
      any_pending <= 1'b0;
      found       <= 1'b0;
    end else if (cmp_en && entry_valid[cmp_idx]) begin
      any_pending <= 1'b1;
      if ((TIME_W'(ram_rdata.arrival) <= current_time) && better) begin
        found    <= 1'b1;
        best_idx <= cmp_idx;
        best     <= ram_rdata;
      end
    end
    cmp_idx <= scan_idx;

    unique case (state)
      S_IDLE: begin
        if (s_fire) begin
          if (s_tuser == KIND_LOAD) begin
            res <= '{status:    table_full ? ST_FULL : ST_LOADED,
                     job_index: table_full ? 4'd0 : cnt_idx_ext[3:0],
                     default:   '0};
          end else begin
            res <= '{status: ST_CLEARED, default: '0};
          end
        end
      end
      S_DECIDE: begin
        res.slice_start <= current_time;
        len <= (best.remaining < {{(FIELD_W - Q_W){1'b0}}, q_eff}) ?
               best.remaining[Q_W-1:0] : q_eff;
        if (!any_pending) begin
          res.status <= ST_DONE;
        end else if (!found) begin
          res.status       <= ST_IDLE;
          res.slice_length <= Q_W'(1);
        end
      end
      S_RUN: begin
        res.status       <= ST_RAN;
        res.job_index    <= best_idx_ext[3:0];
        res.slice_length <= len;
        res.finished     <= (rem_next == '0);
      end
      S_TA: begin
        res.finish_time <= current_time;
        res.turnaround  <= current_time - TIME_W'(best.arrival);
      end
      S_WT: begin
        res.waiting_time <= (res.turnaround >= TIME_W'(best.burst)) ?
                            res.turnaround - TIME_W'(best.burst) : '0;
      end
      default: begin
      end
    endcase
  end

  // output register: holds one result beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_free) begin
      out_q <= res;
    end
  end

  assign m_tuser = out_q.status;
  assign m_tdata = {3'b000, out_q.waiting_time, out_q.turnaround, out_q.finish_time,
                    out_q.finished, out_q.slice_length, out_q.slice_start,
                    out_q.job_index};

  // table never holds more jobs than slots
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(ENTRIES))
    else $error("entry_count above table size");

  // a finishing slice retires its job
  a_retire: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) && (rem_next == '0) |=> !entry_valid[best_idx])
    else $error("finished job still valid");

  // the clock only moves forward while a step is worked on
  a_clock_mono: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> current_time >= $past(current_time))
    else $error("clock went backward during a step");

  // an idle tick always spans one time unit
  a_idle_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_IDLE) |-> m_tdata[35:28] == 8'd1)
    else $error("idle tick with wrong length");

  // only a run slice can report completion
  a_fin_ran: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[36] |-> m_tuser == ST_RAN)
    else $error("finished flag on non-run result");

endmodule

@@ verif/shortest_remaining_time_scheduler_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_remaining_time_scheduler_tb
// Self-checking bench for the SRT scheduler. A scoreboard class keeps its own
// job table, clock and quantum, predicts the result beat of every accepted
// load, step or clear beat and compares each result beat field by field. A
// short directed run covers the corner cases. Random phases follow: clear, a
// batch of loads with steps mixed in, then steps until the table drains or a
// step limit is hit. Both handshake sides stall at random.
// ----------------------------------------------------------------------------

class sched_scoreboard #(int SLOTS = 16);
  bit                 live      [SLOTS];
  logic [15:0]        arrival   [SLOTS];
  logic [15:0]        remaining [SLOTS];
  logic [15:0]        burst     [SLOTS];
  int unsigned        loaded;
  logic [23:0]        sched_clock;
  logic [7:0]         quantum;
  srt_pkg::result_t   expected_results[$];
  int unsigned        errors;

  function new();
    foreach (live[i]) live[i] = 1'b0;
    loaded      = 0;
    sched_clock = '0;
    quantum     = 8'd1;
    errors      = 0;
  endfunction

  // clock stops at all ones
  function void advance_clock(logic [15:0] delta);
    logic [24:0] sum;
    sum = {1'b0, sched_clock} + {9'd0, delta};
    sched_clock = sum[24] ? 24'hFFFFFF : sum[23:0];
  endfunction

  function int unsigned pending_jobs();
    int unsigned n;
    n = 0;
    foreach (live[i]) begin
      if (live[i]) n++;
    end
    return n;
  endfunction

  // Apply one accepted input beat to the model table and queue its result, if any.
  function void accept_item(logic [1:0] kind, logic [15:0] arr, logic [15:0] len_in);
    srt_pkg::result_t r;
    int               pick;
    bit               pending;
    logic [15:0]      q;
    logic [15:0]      run_len;
    logic [23:0]      ta;
    r       = '0;
    pick    = -1;
    pending = 1'b0;
    case (kind)
      srt_pkg::KIND_LOAD: begin
        if (loaded >= SLOTS) begin
          r.status = srt_pkg::ST_FULL;
        end else begin
          live[loaded]      = 1'b1;
          arrival[loaded]   = arr;
          remaining[loaded] = len_in;
          burst[loaded]     = len_in;
          r.status          = srt_pkg::ST_LOADED;
          r.job_index       = loaded[3:0];
          loaded++;
        end
      end
      srt_pkg::KIND_CLEAR: begin
        foreach (live[i]) live[i] = 1'b0;
        loaded      = 0;
        sched_clock = '0;
        r.status    = srt_pkg::ST_CLEARED;
      end
      srt_pkg::KIND_STEP: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (live[i]) begin
            pending = 1'b1;
            // least remaining, then earliest arrival, then lowest slot
            if ({8'd0, arrival[i]} <= sched_clock &&
                (pick < 0 || remaining[i] < remaining[pick] ||
                 (remaining[i] == remaining[pick] && arrival[i] < arrival[pick])))
              pick = i;
          end
        end
        r.slice_start = sched_clock;
        if (!pending) begin
          r.status = srt_pkg::ST_DONE;
        end else if (pick < 0) begin
          r.status       = srt_pkg::ST_IDLE;
          r.slice_length = 8'd1;
          advance_clock(16'd1);
        end else begin
          q              = (quantum == 8'd0) ? 16'd1 : {8'd0, quantum};
          run_len        = (remaining[pick] < q) ? remaining[pick] : q;
          r.status       = srt_pkg::ST_RAN;
          r.job_index    = pick[3:0];
          r.slice_length = run_len[7:0];
          advance_clock(run_len);
          remaining[pick] -= run_len;
          if (remaining[pick] == 16'd0) begin
            live[pick]     = 1'b0;
            r.finished     = 1'b1;
            r.finish_time  = sched_clock;
            ta             = sched_clock - {8'd0, arrival[pick]};
            r.turnaround   = ta;
            r.waiting_time = (ta >= {8'd0, burst[pick]}) ? ta - {8'd0, burst[pick]} : '0;
          end
        end
      end
      default: return;  // unused kind: no result beat
    endcase
    expected_results.push_back(r);
  endfunction

  function void compare_field(string name, logic [23:0] exp_val, logic [23:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      errors++;
    end
  endfunction

  function void check_result(logic [2:0] status, logic [111:0] data);
    srt_pkg::result_t e;
    if (expected_results.size() == 0) begin
      $error("result beat with none expected: status %0d", status);
      errors++;
      return;
    end
    e = expected_results.pop_front();
    compare_field("status",       24'(e.status),       24'(status));
    compare_field("job_index",    24'(e.job_index),    24'(data[3:0]));
    compare_field("slice_start",  e.slice_start,       data[27:4]);
    compare_field("slice_length", 24'(e.slice_length), 24'(data[35:28]));
    compare_field("finished",     24'(e.finished),     24'(data[36]));
    compare_field("finish_time",  e.finish_time,       data[60:37]);
    compare_field("turnaround",   e.turnaround,        data[84:61]);
    compare_field("waiting_time", e.waiting_time,      data[108:85]);
  endfunction
endclass

module shortest_remaining_time_scheduler_tb
  import srt_pkg::*;
();

  localparam int          SLOTS         = 16;
  localparam int          SETTLE_CYCLES = SLOTS + 16;  // beyond the longest step
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          ITEM_TARGET   = 1250;
  localparam logic [1:0]  KIND_UNUSED   = 2'd3;

  logic         clk       = 1'b0;
  logic         rst       = 1'b1;
  logic         cfg_we    = 1'b0;
  logic [7:0]   cfg_wdata = '0;
  logic         s_tvalid  = 1'b0;
  logic         s_tready;
  logic [31:0]  s_tdata   = '0;   // [15:0] arrival_time, [31:16] burst_time
  logic [1:0]   s_tuser   = '0;   // [1:0] kind
  logic         m_tvalid;
  logic         m_tready  = 1'b0;
  logic [111:0] m_tdata;          // job_index .. waiting_time, see dut port list
  logic [2:0]   m_tuser;          // [2:0] status

  sched_scoreboard #(SLOTS) sb;
  int unsigned items_sent = 0;
  bit          calm       = 1'b0;  // no stalls on either side while set

  shortest_remaining_time_scheduler #(.ENTRIES(SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #6 clk = ~clk;

  // result side: random backpressure
  always @(negedge clk) begin
    m_tready <= calm || ($urandom_range(0, 99) >= 12);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
  end

  // Present one beat at a falling edge, hold it until taken.
  task automatic send_item(logic [1:0] kind, logic [15:0] arr, logic [15:0] len_in);
    while (!calm && $urandom_range(0, 99) < 12) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {len_in, arr};
    do @(posedge clk); while (!s_tready);
    sb.accept_item(kind, arr, len_in);
    if (kind != KIND_UNUSED) items_sent++;
    calm = (items_sent >= 600 && items_sent < 800);
    @(negedge clk);
  endtask

  // Quantum writes only with the block drained; an unused-kind beat may still
  // be in flight, so give it the full step time as well.
  task automatic set_quantum(logic [7:0] q);
    s_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= q;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.quantum = q;
  endtask

  // One random phase: clear, loads with steps mixed in, then drain.
  task automatic run_phase();
    int unsigned n_jobs;
    int unsigned steps;
    logic [15:0] arr;
    logic [15:0] len_in;
    n_jobs = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 8);
    send_item(KIND_CLEAR, 16'($urandom), 16'($urandom));
    for (int j = 0; j < n_jobs; j++) begin
      if ($urandom_range(0, 29) == 0) send_item(KIND_UNUSED, 16'($urandom), 16'($urandom));
      if ($urandom_range(0, 5) == 0) send_item(KIND_STEP, 16'($urandom), 16'($urandom));
      // mostly short jobs that arrive early; now and then full-range values
      arr    = ($urandom_range(0, 24) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
      len_in = ($urandom_range(0, 24) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
      send_item(KIND_LOAD, arr, len_in);
    end
    steps = 0;
    while (sb.pending_jobs() != 0 && steps < 150) begin
      send_item(KIND_STEP, 16'($urandom), 16'($urandom));
      steps++;
    end
    send_item(KIND_STEP, 16'($urandom), 16'($urandom));  // all done once drained
  endtask

  initial begin
    sb = new();
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- directed, quantum 1 from reset ---
    send_item(KIND_STEP, 16'd0, 16'd0);             // empty table: all done
    send_item(KIND_UNUSED, 16'hFFFF, 16'hFFFF);     // ignored, no beat
    send_item(KIND_LOAD, 16'd3, 16'd0);             // zero burst, arrives later
    send_item(KIND_LOAD, 16'hFFFF, 16'hFFFF);       // field extremes
    send_item(KIND_STEP, 16'd0, 16'd0);             // idle ticks until t=3
    send_item(KIND_STEP, 16'd0, 16'd0);
    send_item(KIND_STEP, 16'd0, 16'd0);
    send_item(KIND_STEP, 16'd0, 16'd0);             // zero-length slice, finishes
    send_item(KIND_LOAD, 16'd0, 16'd2);
    send_item(KIND_LOAD, 16'd0, 16'd2);             // full tie: lower slot wins
    send_item(KIND_STEP, 16'd0, 16'd0);
    send_item(KIND_STEP, 16'd0, 16'd0);
    send_item(KIND_STEP, 16'd0, 16'd0);
    send_item(KIND_CLEAR, 16'd0, 16'd0);

    set_quantum(8'd255);
    send_item(KIND_LOAD, 16'd0, 16'd300);           // longer than one quantum
    send_item(KIND_LOAD, 16'd1, 16'd5);             // shorter job preempts
    send_item(KIND_STEP, 16'd0, 16'd0);
    send_item(KIND_STEP, 16'd0, 16'd0);
    send_item(KIND_STEP, 16'd0, 16'd0);
    send_item(KIND_STEP, 16'd0, 16'd0);

    set_quantum(8'd0);                              // behaves as quantum 1
    send_item(KIND_LOAD, 16'd10, 16'd3);
    send_item(KIND_LOAD, 16'd0, 16'd3);             // same remaining, earlier arrival
    send_item(KIND_STEP, 16'd0, 16'd0);
    send_item(KIND_STEP, 16'd0, 16'd0);

    // --- random phases ---
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0:       set_quantum(8'd0);
          1:       set_quantum(8'd1);
          2:       set_quantum(8'd255);
          3, 4:    set_quantum(8'($urandom_range(1, 6)));
          default: set_quantum(8'($urandom_range(1, 255)));
        endcase
      end
      run_phase();
    end

    s_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0)
      $display("shortest_remaining_time_scheduler_tb: done, clean");
    else
      $display("shortest_remaining_time_scheduler_tb: done, errors");
    $finish;
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("shortest_remaining_time_scheduler_tb: done, errors");
    $finish;
  end

endmodule
